@@ rtl/swm_pkg.sv @@
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and defaults for the sliding window maximum block.
// ----------------------------------------------------------------------------
package swm_pkg;

  // default sizes
  localparam int WINDOW_MAX_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  // width of the window size register
  localparam int WSIZE_W = 7;

  // how far the candidate row moves towards the head in one update
  typedef enum logic [1:0] {
    SHIFT_NONE,
    SHIFT_ONE,
    SHIFT_TWO
  } shift_t;

  // control broadcast from the top level to every cell
  typedef struct packed {
    logic   en;     // update the row this cycle
    logic   clear;  // item starts a new sequence
    shift_t shift;  // head removals after append
  } cell_ctrl_t;

endpackage

@@ rtl/swm_cell.sv @@
// ----------------------------------------------------------------------------
// swm_cell
// One slot of the candidate queue, held as a position counted from the head.
// Works out its value after the tail drop and append, and takes its new value
// from itself or from one of the next two slots when the head is removed.
// ----------------------------------------------------------------------------
module swm_cell #(
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  swm_pkg::cell_ctrl_t           ctrl,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          keep_left,  // slot before this one survives
  input  logic                          nb1_vld,    // slot one further on
  input  logic signed [SAMPLE_BITS-1:0] nb1_val,
  input  logic                          nb2_vld,    // slot two further on
  input  logic signed [SAMPLE_BITS-1:0] nb2_val,
  output logic                          keep,
  output logic                          app_vld,    // slot after append
  output logic signed [SAMPLE_BITS-1:0] app_val
);
  import swm_pkg::*;

  logic                          vld;
  logic signed [SAMPLE_BITS-1:0] val;
  logic                          vld_next;
  logic signed [SAMPLE_BITS-1:0] val_next;

  // survives the drop unless strictly smaller than the new sample
  assign keep    = vld && !ctrl.clear && !(val < sample);
  // first dropped slot takes the new sample
  assign app_vld = keep || keep_left;
  assign app_val = keep ? val : sample;

  // head removal moves the row
  always_comb begin
    case (ctrl.shift)
      SHIFT_NONE: begin
        vld_next = app_vld;
        val_next = app_val;
      end
      SHIFT_ONE: begin
        vld_next = nb1_vld;
        val_next = nb1_val;
      end
      SHIFT_TWO: begin
        vld_next = nb2_vld;
        val_next = nb2_val;
      end
      default: begin
        vld_next = app_vld;
        val_next = app_val;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (ctrl.en) begin
      vld <= vld_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      val <= val_next;
    end
  end

endmodule

@@ rtl/swm_hist.sv @@
// ----------------------------------------------------------------------------
// swm_hist
// Ring of recent samples. Writes the arriving sample and reads the one that
// leaves the window, lag items back, into a register in the same cycle.
// ----------------------------------------------------------------------------
module swm_hist #(
  parameter int DEPTH  = swm_pkg::WINDOW_MAX_DEF,
  parameter int DATA_W = swm_pkg::SAMPLE_BITS_DEF,
  parameter int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr,     // item accepted
  input  logic                     clear,  // restart the write position
  input  logic signed [DATA_W-1:0] din,
  input  logic [IDX_W-1:0]         lag,    // window size minus one
  output logic signed [DATA_W-1:0] dout
);
  import swm_pkg::*;

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic [IDX_W-1:0]         pos;
  logic [IDX_W-1:0]         pos_eff;
  logic [IDX_W-1:0]         pos_next;
  logic [IDX_W:0]           back;
  logic [IDX_W-1:0]         raddr;

  assign pos_eff  = clear ? '0 : pos;
  assign pos_next = (pos_eff == IDX_W'(DEPTH - 1)) ? '0 : pos_eff + IDX_W'(1);

  // read address wraps modulo the depth
  always_comb begin
    back = {1'b0, pos_eff} + (IDX_W + 1)'(DEPTH) - {1'b0, lag};
    if (back >= (IDX_W + 1)'(DEPTH)) begin
      back = back - (IDX_W + 1)'(DEPTH);
    end
    raddr = back[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (wr) begin
      pos <= pos_next;
    end
  end

  // storage, registered read
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[pos_eff] <= din;
      dout         <= mem[raddr];
    end
  end

endmodule

@@ rtl/sliding_window_max.sv @@
// ----------------------------------------------------------------------------
// sliding_window_max
// Running maximum of the last window_size signed samples of a stream.
// ----------------------------------------------------------------------------
// Usage:
//   window_size is written through window_size_we while the block is idle;
//   zero acts as a window of one, values above WINDOW_MAX act as WINDOW_MAX.
//   Input items (sample, first) arrive on in_valid/in_ready. first restarts
//   the sequence: queue and counters clear before that sample is taken.
//   Once window_size samples of the sequence have arrived, each item gives
//   one window_max item on out_valid/out_ready; earlier items give none.
// Timing:
//   One item per clock sustained while out_ready stays high. An accepted
//   item is registered in the first stage, where the history ring also
//   registers the leaving sample; as that stage advances, the row of
//   candidate cells updates and the output register loads the result.
// Reset:
//   Synchronous rst empties the queue, zeroes the counters and sets the
//   window to one sample. The history needs no clearing.
// Stall:
//   The output register holds its item while out_ready is low; one more
//   item waits in the first stage, after which in_ready drops.
// ----------------------------------------------------------------------------
module sliding_window_max #(
  parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          window_size_we,
  input  logic [swm_pkg::WSIZE_W-1:0]   window_size,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          first,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] window_max
);
  import swm_pkg::*;

  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  // configuration, held as the effective window
  logic [CNT_W-1:0] win;
  logic [CNT_W-1:0] win_next;

  // sample counter
  logic [CNT_W-1:0] seen;
  logic [CNT_W-1:0] seen_base;
  logic [CNT_W:0]   seen_inc;
  logic [CNT_W-1:0] seen_next;

  // first stage
  logic                          in_acc;
  logic                          a_valid;
  logic signed [SAMPLE_BITS-1:0] a_sample;
  logic                          a_first;
  logic                          a_emit;
  logic                          a_w1;
  logic signed [SAMPLE_BITS-1:0] hist_rd;
  logic [IDX_W-1:0]              lag;

  // second stage
  logic                          b_adv;
  logic signed [SAMPLE_BITS-1:0] leaving;
  logic signed [SAMPLE_BITS-1:0] head;
  logic                          full;
  logic                          pop;
  cell_ctrl_t                    ctrl;

  // cell row, with two virtual slots past the end
  logic                          keep    [WINDOW_MAX];
  logic                          app_vld [WINDOW_MAX + 2];
  logic signed [SAMPLE_BITS-1:0] app_val [WINDOW_MAX + 2];

  // saturate the window size as written
  always_comb begin
    if (window_size == '0) begin
      win_next = CNT_W'(1);
    end else if (32'(window_size) > 32'(WINDOW_MAX)) begin
      win_next = CNT_W'(WINDOW_MAX);
    end else begin
      win_next = CNT_W'(window_size);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= CNT_W'(1);
    end else if (window_size_we) begin
      win <= win_next;
    end
  end

  // handshake
  assign b_adv    = a_valid && (!a_emit || !out_valid || out_ready);
  assign in_ready = !a_valid || b_adv;
  assign in_acc   = in_valid && in_ready;

  // count samples of the sequence, saturating at the window
  always_comb begin
    seen_base = first ? '0 : seen;
    seen_inc  = {1'b0, seen_base} + (CNT_W + 1)'(1);
    if (seen_inc > {1'b0, win}) begin
      seen_next = win;
    end else begin
      seen_next = seen_inc[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (in_acc) begin
      seen <= seen_next;
    end
  end

  assign lag = IDX_W'(win - CNT_W'(1));

  swm_hist #(
    .DEPTH  (WINDOW_MAX),
    .DATA_W (SAMPLE_BITS),
    .IDX_W  (IDX_W)
  ) u_hist (
    .clk   (clk),
    .rst   (rst),
    .wr    (in_acc),
    .clear (first),
    .din   (sample),
    .lag   (lag),
    .dout  (hist_rd)
  );

  // first stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_acc) begin
      a_valid <= 1'b1;
    end else if (b_adv) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_sample <= sample;
      a_first  <= first;
      a_emit   <= (seen_next == win);
      a_w1     <= (win == CNT_W'(1));
    end
  end

  // a one-sample window loses the sample just taken
  assign leaving = a_w1 ? a_sample : hist_rd;

  // slots past the end: the new sample lands there only when the row is full
  assign full                   = keep[WINDOW_MAX-1];
  assign app_vld[WINDOW_MAX]    = full;
  assign app_val[WINDOW_MAX]    = a_sample;
  assign app_vld[WINDOW_MAX+1]  = 1'b0;
  assign app_val[WINDOW_MAX+1]  = a_sample;

  // head after append; a full row first gives up its old head
  assign head = full ? app_val[1] : app_val[0];
  assign pop  = a_emit && (head == leaving);

  always_comb begin
    ctrl.en    = b_adv;
    ctrl.clear = a_first;
    case ({full, pop})
      2'b00:   ctrl.shift = SHIFT_NONE;
      2'b11:   ctrl.shift = SHIFT_TWO;
      default: ctrl.shift = SHIFT_ONE;
    endcase
  end

  // row of candidate cells, head at index 0
  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic keep_left;
    if (i == 0) begin : g_head
      assign keep_left = 1'b1;
    end else begin : g_body
      assign keep_left = keep[i-1];
    end

    swm_cell #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .sample    (a_sample),
      .keep_left (keep_left),
      .nb1_vld   (app_vld[i+1]),
      .nb1_val   (app_val[i+1]),
      .nb2_vld   (app_vld[i+2]),
      .nb2_val   (app_val[i+2]),
      .keep      (keep[i]),
      .app_vld   (app_vld[i]),
      .app_val   (app_val[i])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_adv && a_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv && a_emit) begin
      window_max <= head;
    end
  end

endmodule

@@ bench/sliding_window_max_test.sv @@
// ----------------------------------------------------------------------------
// sliding_window_max_test
// Self-checking bench for the sliding window maximum block. A short table of
// hand-picked items comes first (extremes, window size corner values, size
// changes inside a sequence), then a long falling run with a shrink, then
// shaped random streams over several window sizes and handshake idling phases.
// A local queue model predicts CHK_PRED results; all are checked in order.
// ----------------------------------------------------------------------------
module sliding_window_max_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH         = swm_pkg::WINDOW_MAX_DEF;
  localparam int SAMPLE_BITS   = swm_pkg::SAMPLE_BITS_DEF;
  localparam int WSIZE_W       = swm_pkg::WSIZE_W;
  localparam int HALF_PERIOD   = 6;
  localparam int LATENCY_SLACK = 6;       // pipeline is two deep
  localparam int HOLD_CYCLES   = 200;     // long receiver hold-off
  localparam int ITEM_TARGET   = 1450;
  localparam int PHASE_ITEMS   = 110;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PRINT_LIMIT   = 100;
  localparam int DIRECTED_ROWS = 23;
  localparam int EXP_DEPTH     = 8;       // results in flight

  // how a table row is checked
  typedef enum logic [1:0] {
    CHK_PRED,   // take the local model's answer
    CHK_NONE,   // no result may come from this item
    CHK_VAL     // result typed into the table
  } check_kind_t;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  typedef enum logic [1:0] {
    SHAPE_ANY,
    SHAPE_NARROW,
    SHAPE_FALLING,
    SHAPE_RISING
  } sample_shape_t;

  typedef struct packed {
    logic                          set_win;
    logic [WSIZE_W-1:0]            win;
    logic signed [SAMPLE_BITS-1:0] smp;
    logic                          frst;
    check_kind_t                   kind;
    logic signed [SAMPLE_BITS-1:0] want;
  } stim_row_t;

  // DUT ports
  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          window_size_we = 1'b0;
  logic [WSIZE_W-1:0]            window_size = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic signed [SAMPLE_BITS-1:0] sample = '0;
  logic                          first = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b1;
  logic signed [SAMPLE_BITS-1:0] window_max;

  // check mode travelling with the item on offer
  check_kind_t                   row_kind = CHK_PRED;
  logic signed [SAMPLE_BITS-1:0] row_max = '0;

  // local model of the block
  logic signed [SAMPLE_BITS-1:0] hist_ring [DEPTH];
  logic signed [SAMPLE_BITS-1:0] cand_ring [DEPTH];
  int                            cand_len;
  int                            cand_head;
  int                            hist_wr;
  int                            seen_count;
  logic [WSIZE_W-1:0]            win_reg;

  // expected results, oldest at exp_head
  logic signed [SAMPLE_BITS-1:0] expected_max [EXP_DEPTH];
  int                            exp_head  = 0;
  int                            exp_count = 0;

  int mismatches   = 0;
  int cycle_count  = 0;
  int items_sent   = 0;
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int hold_req     = 0;
  int hold_seen    = 0;
  int hold_left    = 0;
  int ramp_level   = 0;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // window of one after reset: result is the sample itself
    '{1'b0, 7'd0,   16'sd32767,  1'b1, CHK_VAL,  16'sd32767},
    '{1'b0, 7'd0,   16'sh8000,   1'b0, CHK_VAL,  16'sh8000},
    '{1'b0, 7'd0,   16'sd0,      1'b0, CHK_VAL,  16'sd0},
    // size zero acts as one
    '{1'b1, 7'd0,   -16'sd1,     1'b0, CHK_VAL,  -16'sd1},
    // window of three, fill then slide with ties
    '{1'b1, 7'd3,   16'sd5,      1'b1, CHK_NONE, 16'sd0},
    '{1'b0, 7'd0,   16'sd3,      1'b0, CHK_NONE, 16'sd0},
    '{1'b0, 7'd0,   16'sd7,      1'b0, CHK_VAL,  16'sd7},
    '{1'b0, 7'd0,   16'sd7,      1'b0, CHK_PRED, 16'sd0},
    '{1'b0, 7'd0,   16'sd1,      1'b0, CHK_PRED, 16'sd0},
    '{1'b0, 7'd0,   16'sd1,      1'b0, CHK_PRED, 16'sd0},
    '{1'b0, 7'd0,   -16'sd4,     1'b0, CHK_PRED, 16'sd0},
    // oversize register saturates to the full window
    '{1'b1, 7'd127, 16'sd100,    1'b1, CHK_NONE, 16'sd0},
    '{1'b0, 7'd0,   -16'sd7,     1'b0, CHK_NONE, 16'sd0},
    // shrink inside the sequence
    '{1'b1, 7'd2,   16'sd50,     1'b0, CHK_PRED, 16'sd0},
    '{1'b0, 7'd0,   16'sd60,     1'b0, CHK_PRED, 16'sd0},
    '{1'b1, 7'd65,  16'sh8000,   1'b1, CHK_NONE, 16'sd0},
    '{1'b0, 7'd0,   16'sd32767,  1'b0, CHK_NONE, 16'sd0},
    // shrink to one leaves a stale head in the queue
    '{1'b1, 7'd1,   16'sd0,      1'b0, CHK_PRED, 16'sd0},
    '{1'b0, 7'd0,   -16'sd5,     1'b0, CHK_PRED, 16'sd0},
    '{1'b0, 7'd0,   16'sd12345,  1'b1, CHK_VAL,  16'sd12345},
    // grow inside the sequence
    '{1'b1, 7'd4,   16'sd9,      1'b0, CHK_PRED, 16'sd0},
    '{1'b0, 7'd0,   16'sd9,      1'b0, CHK_PRED, 16'sd0},
    '{1'b0, 7'd0,   16'sd9,      1'b0, CHK_PRED, 16'sd0}
  };

  sliding_window_max DUT (
    .clk            (clk),
    .rst            (rst),
    .window_size_we (window_size_we),
    .window_size    (window_size),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .sample         (sample),
    .first          (first),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .window_max     (window_max)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sliding_window_max regression: fail");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_LIMIT)
      $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // add one expected result behind the others
  task automatic exp_put(input logic signed [SAMPLE_BITS-1:0] v);
    if (exp_count >= EXP_DEPTH) begin
      report_mismatch("more results in flight than the pipeline holds");
    end else begin
      expected_max[(exp_head + exp_count) % EXP_DEPTH] = v;
      exp_count++;
    end
  endtask

  // Advance the candidate queue by one sample; returns 1 when a window max
  // comes out of this item.
  function automatic bit advance_window(input logic signed [SAMPLE_BITS-1:0] s,
                                        input logic restart,
                                        output logic signed [SAMPLE_BITS-1:0] peak);
    int w;
    logic signed [SAMPLE_BITS-1:0] leaving;
    w = (win_reg == 0) ? 1 : (win_reg > DEPTH) ? DEPTH : int'(win_reg);
    peak = '0;
    if (restart) begin
      cand_len   = 0;
      cand_head  = 0;
      hist_wr    = 0;
      seen_count = 0;
    end
    // drop smaller tail entries, make room if still full, append
    while (cand_len > 0 && cand_ring[(cand_head + cand_len - 1) % DEPTH] < s)
      cand_len--;
    if (cand_len >= DEPTH) begin
      cand_head = (cand_head + 1) % DEPTH;
      cand_len--;
    end
    cand_ring[(cand_head + cand_len) % DEPTH] = s;
    cand_len++;
    // history ring supplies the sample leaving the window
    hist_ring[hist_wr] = s;
    leaving = hist_ring[(hist_wr + DEPTH - (w - 1)) % DEPTH];
    hist_wr = (hist_wr + 1) % DEPTH;
    seen_count = (seen_count + 1 > w) ? w : seen_count + 1;
    if (seen_count < w)
      return 1'b0;
    peak = cand_ring[cand_head];
    if (peak == leaving) begin
      cand_head = (cand_head + 1) % DEPTH;
      cand_len--;
    end
    return 1'b1;
  endfunction

  // Model update and result check, all at the rising edge in one process
  always @(posedge clk) begin : watch
    logic signed [SAMPLE_BITS-1:0] peak;
    logic signed [SAMPLE_BITS-1:0] want;
    bit produced;
    if (rst) begin
      foreach (hist_ring[i]) begin
        hist_ring[i] = '0;
        cand_ring[i] = '0;
      end
      cand_len   = 0;
      cand_head  = 0;
      hist_wr    = 0;
      seen_count = 0;
      win_reg    = WSIZE_W'(1);
      exp_head   = 0;
      exp_count  = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (exp_count == 0) begin
          report_mismatch($sformatf("window_max %0d with no item expected", window_max));
        end else begin
          want = expected_max[exp_head];
          exp_head = (exp_head + 1) % EXP_DEPTH;
          exp_count--;
          if (window_max !== want)
            report_mismatch($sformatf("window_max %0d, expected %0d", window_max, want));
        end
      end
      if (window_size_we)
        win_reg = window_size;
      if (in_valid && in_ready) begin
        produced = advance_window(sample, first, peak);
        case (row_kind)
          CHK_VAL:  exp_put(row_max);
          CHK_PRED: if (produced) exp_put(peak);
          default: ;
        endcase
      end
    end
  end

  // Receiver: random stalls plus an occasional long hold-off
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct);
    end
  end

  // Offer one item; returns at the falling edge after it is taken, valid
  // still high so that a following item keeps the line busy.
  task automatic offer_item(input logic signed [SAMPLE_BITS-1:0] s, input logic f,
                            input check_kind_t k, input logic signed [SAMPLE_BITS-1:0] v);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    sample   = s;
    first    = f;
    row_kind = k;
    row_max  = v;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    @(negedge clk);
  endtask

  // Window size write once the pipeline has drained
  task automatic load_window(input logic [WSIZE_W-1:0] v);
    in_valid = 1'b0;
    while (exp_count != 0) @(negedge clk);
    repeat (LATENCY_SLACK) @(negedge clk);
    window_size_we = 1'b1;
    window_size    = v;
    @(negedge clk);
    window_size_we = 1'b0;
  endtask

  // A run of samples; ramps keep their level across calls unless restarted
  task automatic run_stream(input int len, input logic lead_first, input bit noisy,
                            input sample_shape_t shape);
    logic signed [SAMPLE_BITS-1:0] s;
    logic f;
    if (lead_first && shape == SHAPE_FALLING)
      ramp_level = 32767 - $urandom_range(0, 1000);
    else if (lead_first && shape == SHAPE_RISING)
      ramp_level = -32768 + $urandom_range(0, 1000);
    for (int i = 0; i < len; i++) begin
      case (shape)
        SHAPE_NARROW: s = SAMPLE_BITS'(int'($urandom_range(0, 7)) - 4);
        SHAPE_FALLING: begin
          ramp_level = ramp_level - $urandom_range(1, 200);
          if (ramp_level < -32768) ramp_level = -32768;
          s = ramp_level[SAMPLE_BITS-1:0];
        end
        SHAPE_RISING: begin
          ramp_level = ramp_level + $urandom_range(0, 200);
          if (ramp_level > 32767) ramp_level = 32767;
          s = ramp_level[SAMPLE_BITS-1:0];
        end
        default: s = SAMPLE_BITS'($urandom);
      endcase
      f = noisy ? logic'($urandom_range(1)) : (i == 0 && lead_first);
      offer_item(s, f, CHK_PRED, '0);
    end
  endtask

  initial begin : stimulus
    int phase;
    int eff;
    int len;
    int r;
    int phase_items;
    int random_target;
    logic [WSIZE_W-1:0] win;
    logic lead;
    idle_mode_t mode;
    sample_shape_t shape;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].set_win)
        load_window(directed_rows[i].win);
      offer_item(directed_rows[i].smp, directed_rows[i].frst,
                 directed_rows[i].kind, directed_rows[i].want);
    end
    random_target = ITEM_TARGET;

    // Long strictly falling run fills the queue at full window; a shrink
    // inside the sequence then forces the head out to make room.
    load_window(7'(DEPTH));
    run_stream(90, 1'b1, 1'b0, SHAPE_FALLING);
    load_window(7'($urandom_range(1, 4)));
    run_stream(30, 1'b0, 1'b0, SHAPE_FALLING);

    // random phases
    phase = 0;
    while (items_sent < random_target) begin
      case (phase % 7)
        0:       win = 7'd1;
        1:       win = 7'(DEPTH);
        2:       win = 7'd0;
        3:       win = 7'd127;
        4:       win = 7'($urandom_range(DEPTH + 1, 126));
        default: win = 7'($urandom_range(2, DEPTH - 1));
      endcase
      load_window(win);
      eff = (win == 0) ? 1 : (win > DEPTH) ? DEPTH : int'(win);

      mode = idle_mode_t'(phase % 4);
      case (mode)
        IDLE_SENDER:   begin tx_idle_pct = 61; rx_stall_pct <= 0;  end
        IDLE_RECEIVER: begin tx_idle_pct = 0;  rx_stall_pct <= 61; end
        IDLE_BOTH:     begin tx_idle_pct = 22; rx_stall_pct <= 22; end
        default:       begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
      endcase
      // back-pressure: receiver holds off while the sender keeps offering
      if (phase % 8 == 0)
        hold_req <= hold_req + 1;

      // some phases carry on the previous sequence across the size change
      lead = (phase % 3 != 1);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS && items_sent < random_target) begin
        r = $urandom_range(9);
        shape = (r < 5) ? SHAPE_ANY : (r < 8) ? SHAPE_NARROW :
                (r == 8) ? SHAPE_FALLING : SHAPE_RISING;
        r = $urandom_range(99);
        if (r < 75) begin
          len = eff + $urandom_range(0, 40);
          run_stream(len, lead, 1'b0, shape);
        end else if (r < 90) begin
          len = $urandom_range(1, eff);
          run_stream(len, lead, 1'b0, shape);
        end else begin
          len = $urandom_range(1, 10);
          run_stream(len, lead, 1'b1, shape);
        end
        lead = 1'b1;
        phase_items += len;
      end
      phase++;
    end

    // drain
    in_valid = 1'b0;
    while (exp_count != 0) @(negedge clk);
    repeat (LATENCY_SLACK) @(negedge clk);
    if (mismatches == 0) begin
      $display("sliding_window_max regression: pass");
    end else begin
      $display("sliding_window_max regression: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/swm_pkg.sv
rtl/swm_cell.sv
rtl/swm_hist.sv
rtl/sliding_window_max.sv
bench/sliding_window_max_test.sv
